@@ hw/rtl/cfb_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfb_pkg
// Shared types, constants and the CRC-8 byte update for the command frame
// builder.
// ----------------------------------------------------------------------------
package cfb_pkg;

  // Frame geometry
  localparam int unsigned FrameLen = 8;
  localparam int unsigned SlotW    = $clog2(FrameLen);

  // Byte slots within a frame
  localparam logic [SlotW-1:0] SlotStart = 3'd0;
  localparam logic [SlotW-1:0] SlotCmd   = 3'd1;
  localparam logic [SlotW-1:0] SlotData0 = 3'd2;
  localparam logic [SlotW-1:0] SlotData1 = 3'd3;
  localparam logic [SlotW-1:0] SlotData2 = 3'd4;
  localparam logic [SlotW-1:0] SlotData3 = 3'd5;
  localparam logic [SlotW-1:0] SlotCrc   = 3'd6;
  localparam logic [SlotW-1:0] SlotEnd   = 3'd7;

  // Configuration register map
  localparam int unsigned      CfgIdxW     = 8;
  localparam logic [CfgIdxW-1:0] RegStartByte = 8'd0;
  localparam logic [CfgIdxW-1:0] RegEndByte   = 8'd1;

  localparam logic [7:0] StartReset = 8'h41;  // 'A'
  localparam logic [7:0] EndReset   = 8'h42;  // 'B'

  // Reflected Dallas/Maxim polynomial
  localparam logic [7:0] CrcPoly = 8'h8C;

  typedef struct packed {
    logic [7:0] start_byte;
    logic [7:0] end_byte;
  } cfg_t;

  // One byte of CRC-8, LSB first
  function automatic logic [7:0] crc8_update(logic [7:0] crc, logic [7:0] data);
    logic [7:0] c;
    logic [7:0] d;
    logic       mix;
    c = crc;
    d = data;
    for (int b = 0; b < 8; b++) begin
      mix = c[0] ^ d[0];
      c   = {1'b0, c[7:1]};
      if (mix) begin
        c = c ^ CrcPoly;
      end
      d = {1'b0, d[7:1]};
    end
    return c;
  endfunction

endpackage

@@ hw/rtl/cfb_cfg_regs.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfb_cfg_regs
// Start and end marker registers, written over the configuration channel.
// Writes to an unknown index are dropped.
// ----------------------------------------------------------------------------
module cfb_cfg_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [cfb_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [7:0]                   cfg_data_i,
  output cfb_pkg::cfg_t                cfg_o
);

  cfb_pkg::cfg_t cfg_d, cfg_q;
  logic          wr_en;

  // Always able to take a write
  assign cfg_ready_o = 1'b1;
  assign wr_en       = cfg_valid_i && cfg_ready_o;

  // Register decode
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      if (cfg_index_i == cfb_pkg::RegStartByte) begin
        cfg_d.start_byte = cfg_data_i;
      end else if (cfg_index_i == cfb_pkg::RegEndByte) begin
        cfg_d.end_byte = cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_byte <= cfb_pkg::StartReset;
      cfg_q.end_byte   <= cfb_pkg::EndReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ hw/rtl/command_frame_builder_crc8.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// command_frame_builder_crc8
// Turns a command byte and a 32-bit data word into an eight-byte frame.
// ----------------------------------------------------------------------------
// Each accepted command yields eight bytes, one per output transfer: start
// marker, command, data word LSB first, CRC-8 (poly 0x8C reflected, init 0,
// no final xor, over command and data) and end marker, the last flagged by
// is_last_o. The single 8-bit output port sets the command rate. A command
// is held in an input register and the next one is taken in the same cycle
// the end marker is loaded into the output register, so frames stream back
// to back with no gap; from idle a command is loaded into the input register
// and its first byte then into the output register. The CRC is built up one
// byte per cycle as the bytes are loaded and holds while the output stalls.
// The user must change markers only while the block is idle (not enforced).
// ----------------------------------------------------------------------------
module command_frame_builder_crc8 (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // Command input
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [7:0]                   command_i,
  input  logic [31:0]                  payload_i,
  // Frame output
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [7:0]                   frame_byte_o,
  output logic                         is_last_o,
  // Configuration writes
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [cfb_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [7:0]                   cfg_data_i
);

  cfb_pkg::cfg_t cfg;

  logic                      item_valid_d, item_valid_q;
  logic [7:0]                cmd_q;
  logic [31:0]               payload_q;
  logic [cfb_pkg::SlotW-1:0] slot_d, slot_q;
  logic [7:0]                crc_d, crc_q;
  logic                      out_valid_d, out_valid_q;
  logic [7:0]                byte_d, byte_q;
  logic                      last_d, last_q;

  logic in_xfer;
  logic advance;
  logic frame_done;

  // Marker registers
  cfb_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // Handshake: load next byte when the output register is free or draining
  assign advance    = item_valid_q && (!out_valid_q || !out_stall_i);
  assign frame_done = advance && (slot_q == cfb_pkg::SlotEnd);
  assign in_stall_o = item_valid_q && !frame_done;
  assign in_xfer    = in_valid_i && !in_stall_o;

  // Byte select and running CRC
  always_comb begin
    byte_d = 8'h00;
    crc_d  = crc_q;
    unique case (slot_q)
      cfb_pkg::SlotStart: begin
        byte_d = cfg.start_byte;
      end
      cfb_pkg::SlotCmd: begin
        byte_d = cmd_q;
        crc_d  = cfb_pkg::crc8_update(8'h00, cmd_q);
      end
      cfb_pkg::SlotData0: begin
        byte_d = payload_q[7:0];
        crc_d  = cfb_pkg::crc8_update(crc_q, payload_q[7:0]);
      end
      cfb_pkg::SlotData1: begin
        byte_d = payload_q[15:8];
        crc_d  = cfb_pkg::crc8_update(crc_q, payload_q[15:8]);
      end
      cfb_pkg::SlotData2: begin
        byte_d = payload_q[23:16];
        crc_d  = cfb_pkg::crc8_update(crc_q, payload_q[23:16]);
      end
      cfb_pkg::SlotData3: begin
        byte_d = payload_q[31:24];
        crc_d  = cfb_pkg::crc8_update(crc_q, payload_q[31:24]);
      end
      cfb_pkg::SlotCrc: begin
        byte_d = crc_q;
      end
      cfb_pkg::SlotEnd: begin
        byte_d = cfg.end_byte;
      end
      default: begin
        byte_d = 8'h00;
      end
    endcase
    if (!advance) begin
      crc_d = crc_q;
    end
  end

  assign last_d = (slot_q == cfb_pkg::SlotEnd);

  // Control next state
  always_comb begin
    item_valid_d = item_valid_q;
    if (in_xfer) begin
      item_valid_d = 1'b1;
    end else if (frame_done) begin
      item_valid_d = 1'b0;
    end
    slot_d      = advance ? slot_q + cfb_pkg::SlotW'(1) : slot_q;
    out_valid_d = advance || (out_valid_q && out_stall_i);
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
      slot_q       <= cfb_pkg::SlotStart;
      out_valid_q  <= 1'b0;
    end else begin
      item_valid_q <= item_valid_d;
      slot_q       <= slot_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      cmd_q     <= command_i;
      payload_q <= payload_i;
    end
    crc_q <= crc_d;
    if (advance) begin
      byte_q <= byte_d;
      last_q <= last_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign frame_byte_o = byte_q;
  assign is_last_o    = last_q;

endmodule

@@ hw/rtl/cfb_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfb_checker
// Port-level checks for the command frame builder, bound to the top level.
// ----------------------------------------------------------------------------
module cfb_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  input  logic                         in_stall_o,
  input  logic [7:0]                   command_i,
  input  logic [31:0]                  payload_i,
  input  logic                         out_valid_o,
  input  logic                         out_stall_i,
  input  logic [7:0]                   frame_byte_o,
  input  logic                         is_last_o,
  input  logic                         cfg_valid_i,
  input  logic                         cfg_ready_o,
  input  logic [cfb_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [7:0]                   cfg_data_i
);

  logic                      in_xfer;
  logic                      out_xfer;
  logic [cfb_pkg::SlotW-1:0] pos_d, pos_q;
  logic [2:0]                pend_d, pend_q;
  logic [7:0]                crc_d, crc_q;

  assign in_xfer  = in_valid_i && !in_stall_o;
  assign out_xfer = out_valid_o && !out_stall_i;

  // Byte position within the frame, outstanding commands, expected CRC
  always_comb begin
    pos_d  = out_xfer ? pos_q + cfb_pkg::SlotW'(1) : pos_q;
    pend_d = pend_q;
    if (in_xfer && !(out_xfer && is_last_o)) begin
      pend_d = pend_q + 3'd1;
    end else if (!in_xfer && out_xfer && is_last_o) begin
      pend_d = pend_q - 3'd1;
    end
    crc_d = crc_q;
    if (out_xfer) begin
      if (pos_q == cfb_pkg::SlotCmd) begin
        crc_d = cfb_pkg::crc8_update(8'h00, frame_byte_o);
      end else if (pos_q == cfb_pkg::SlotData0 || pos_q == cfb_pkg::SlotData1 ||
                   pos_q == cfb_pkg::SlotData2 || pos_q == cfb_pkg::SlotData3) begin
        crc_d = cfb_pkg::crc8_update(crc_q, frame_byte_o);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= cfb_pkg::SlotStart;
      pend_q <= 3'd0;
      crc_q  <= 8'h00;
    end else begin
      pos_q  <= pos_d;
      pend_q <= pend_d;
      crc_q  <= crc_d;
    end
  end

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(frame_byte_o) && $stable(is_last_o))
    else $error("stalled output byte changed");

  // Last flag only on the eighth byte of every frame
  a_last_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (is_last_o == (pos_q == cfb_pkg::SlotEnd)))
    else $error("is_last out of step with frame position");

  // CRC byte matches the command and data bytes sent before it
  a_crc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (pos_q == cfb_pkg::SlotCrc) |-> (frame_byte_o == crc_q))
    else $error("CRC byte mismatch");

  // No more than two commands in flight, none output without one
  a_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pend_q <= 3'd2) && (out_valid_o -> (pend_q != 3'd0)))
    else $error("outstanding command count out of range");

  // An idle block takes a command at once
  a_idle_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pend_q == 3'd0) |-> !in_stall_o)
    else $error("input stalled with nothing outstanding");

endmodule

bind command_frame_builder_crc8 cfb_checker u_cfb_checker (.*);

@@ bench/tb_command_frame_builder_crc8.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_command_frame_builder_crc8
// Self-checking bench for the command frame builder with CRC-8.
// ----------------------------------------------------------------------------
// Commands are queued by the stimulus process and offered by a clocked driver
// in bursts with random gaps. Every accepted command is turned into its eight
// expected frame bytes by a local frame predictor. A clocked monitor checks
// each output transfer against the oldest expected byte while the receiver
// stalls on its own pattern, including one long hold-off that backs the block
// up. Marker registers are rewritten between phases, only when the block is
// idle, covering the reset values, both extremes and unmapped indexes.
// ----------------------------------------------------------------------------
module tb_command_frame_builder_crc8;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned LongHold   = 80;
  localparam int unsigned DrainWait  = 8;

  // Register indexes that map to nothing and must be ignored
  localparam logic [cfb_pkg::CfgIdxW-1:0] RegUnmapped = 8'd2;
  localparam logic [cfb_pkg::CfgIdxW-1:0] RegTopIndex = 8'hFF;

  typedef struct {
    logic [7:0]  cmd;
    logic [31:0] data;
  } command_t;

  typedef struct {
    logic [7:0] value;
    logic       last;
  } frame_byte_t;

  // DUT connections
  logic                        clk_i       = 1'b0;
  logic                        rst_ni      = 1'b0;
  logic                        in_valid_i  = 1'b0;
  logic                        in_stall_o;
  logic [7:0]                  command_i   = '0;
  logic [31:0]                 payload_i   = '0;
  logic                        out_valid_o;
  logic                        out_stall_i = 1'b0;
  logic [7:0]                  frame_byte_o;
  logic                        is_last_o;
  logic                        cfg_valid_i = 1'b0;
  logic                        cfg_ready_o;
  logic [cfb_pkg::CfgIdxW-1:0] cfg_index_i = '0;
  logic [7:0]                  cfg_data_i  = '0;

  // Local copy of the marker registers
  logic [7:0] start_mark = cfb_pkg::StartReset;
  logic [7:0] end_mark   = cfb_pkg::EndReset;

  command_t    cmd_q[$];
  frame_byte_t expected_bytes[$];

  int unsigned err_count   = 0;
  int unsigned cmds_taken  = 0;
  int unsigned bytes_seen  = 0;
  int unsigned cfg_writes  = 0;
  int unsigned cycle_cnt   = 0;
  int unsigned hold_token  = 0;

  command_frame_builder_crc8 DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .command_i    (command_i),
    .payload_i    (payload_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .frame_byte_o (frame_byte_o),
    .is_last_o    (is_last_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  // Clock
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Work out the eight bytes of one frame and queue them
  function automatic void build_frame(logic [7:0] cmd, logic [31:0] data);
    logic [39:0]       stream;
    logic [7:0]        crc;
    logic              fb;
    logic [7:0]        bytes [cfb_pkg::FrameLen];
    frame_byte_t       entry;
    stream = {data, cmd};
    crc    = 8'h00;
    // reflected CRC: command first, then the data word, LSB first
    for (int i = 0; i < 40; i++) begin
      fb  = crc[0] ^ stream[i];
      crc = crc >> 1;
      if (fb) begin
        crc = crc ^ cfb_pkg::CrcPoly;
      end
    end
    bytes[0] = start_mark;
    bytes[1] = cmd;
    bytes[2] = data[7:0];
    bytes[3] = data[15:8];
    bytes[4] = data[23:16];
    bytes[5] = data[31:24];
    bytes[6] = crc;
    bytes[7] = end_mark;
    for (int k = 0; k < cfb_pkg::FrameLen; k++) begin
      entry.value = bytes[k];
      entry.last  = (k == cfb_pkg::FrameLen - 1);
      expected_bytes.push_back(entry);
    end
  endfunction

  task automatic report_mismatch(string what, logic [7:0] got, logic [7:0] want);
    $display("MISMATCH @%0t byte %0d: %s got %02h want %02h",
             $realtime, bytes_seen, what, got, want);
    err_count++;
  endtask

  // Command driver: bursts of random length with random gaps
  int unsigned burst_left = 0;
  int unsigned gap_left   = 0;
  logic        drv_valid;
  logic [7:0]  drv_cmd;
  logic [31:0] drv_data;
  command_t    drv_item;

  always @(posedge clk_i) begin
    drv_valid = in_valid_i;
    drv_cmd   = command_i;
    drv_data  = payload_i;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        build_frame(command_i, payload_i);
        cmds_taken++;
        drv_valid = 1'b0;
      end
      if (!drv_valid) begin
        if (gap_left != 0) begin
          gap_left--;
        end else if (cmd_q.size() != 0) begin
          drv_item  = cmd_q.pop_front();
          drv_valid = 1'b1;
          drv_cmd   = drv_item.cmd;
          drv_data  = drv_item.data;
          if (burst_left <= 1) begin
            burst_left = ($urandom_range(0, 4) == 0) ? 30 : $urandom_range(1, 10);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left--;
          end
        end
      end
    end
    in_valid_i <= drv_valid;
    command_i  <= drv_cmd;
    payload_i  <= drv_data;
  end

  // Receiver stall pattern, plus a long hold-off on request
  int unsigned hold_seen = 0;
  int unsigned hold_left = 0;
  int unsigned seg_left  = 0;
  int unsigned seg_mode  = 0;
  logic        rx_stall;

  always @(posedge clk_i) begin
    rx_stall = 1'b0;
    if (hold_token != hold_seen) begin
      hold_seen = hold_token;
      hold_left = LongHold;
      rx_stall  = 1'b1;
    end else if (hold_left != 0) begin
      hold_left--;
      rx_stall = 1'b1;
    end else begin
      if (seg_left == 0) begin
        seg_mode = $urandom_range(0, 3);
        seg_left = $urandom_range(10, 50);
      end
      seg_left--;
      case (seg_mode)
        1: rx_stall = ($urandom_range(0, 3) == 0);
        2: rx_stall = ($urandom_range(0, 9) < 6);
        3: rx_stall = (seg_left % 3 == 0);
        default: rx_stall = 1'b0;
      endcase
    end
    out_stall_i <= rx_stall;
  end

  // Output monitor
  frame_byte_t mon_want;

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_bytes.size() == 0) begin
        $display("UNEXPECTED @%0t: byte %02h last %0b with nothing pending",
                 $realtime, frame_byte_o, is_last_o);
        err_count++;
      end else begin
        mon_want = expected_bytes.pop_front();
        if (frame_byte_o !== mon_want.value) begin
          report_mismatch("frame_byte", frame_byte_o, mon_want.value);
        end
        if (is_last_o !== mon_want.last) begin
          report_mismatch("is_last", {7'd0, is_last_o}, {7'd0, mon_want.last});
        end
      end
      bytes_seen++;
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("Timeout after %0d cycles, %0d bytes still pending",
               cycle_cnt, expected_bytes.size());
      $display("Some tests failed");
      $finish;
    end
  end

  // Queue one command (called at a falling edge)
  task automatic push_cmd(logic [7:0] cmd, logic [31:0] data);
    command_t item;
    item.cmd  = cmd;
    item.data = data;
    cmd_q.push_back(item);
  endtask

  // Random commands, biased towards extreme and sparse data words
  task automatic push_random(int unsigned count);
    logic [31:0] data;
    for (int unsigned n = 0; n < count; n++) begin
      case ($urandom_range(0, 3))
        1: data = ($urandom_range(0, 1) == 0) ? 32'h0000_0000 : 32'hFFFF_FFFF;
        2: data = 32'($urandom_range(0, 255)) << (8 * $urandom_range(0, 3));
        default: data = $urandom();
      endcase
      push_cmd(8'($urandom_range(0, 255)), data);
    end
  endtask

  // Wait until all commands are taken and every frame byte has arrived
  task automatic wait_idle();
    @(negedge clk_i);
    while (cmd_q.size() != 0 || in_valid_i || expected_bytes.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (DrainWait) @(negedge clk_i);
  endtask

  // One register transfer on the configuration channel
  task automatic write_reg(logic [cfb_pkg::CfgIdxW-1:0] idx, logic [7:0] value);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      cfb_pkg::RegStartByte: start_mark = value;
      cfb_pkg::RegEndByte:   end_mark   = value;
      default: ;  // unmapped index: no effect
    endcase
    cfg_writes++;
    @(negedge clk_i);
  endtask

  // Stimulus
  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Phase 1: reset markers, directed extremes
    push_cmd(8'h00, 32'h0000_0000);
    push_cmd(8'hFF, 32'hFFFF_FFFF);
    push_cmd(8'h01, 32'h0000_0001);
    push_cmd(8'h80, 32'h8000_0000);
    push_cmd(8'hAA, 32'h5555_5555);
    push_cmd(8'h55, 32'hAAAA_AAAA);
    push_cmd(8'h00, 32'h0000_00FF);
    push_cmd(8'h00, 32'h0000_FF00);
    push_cmd(8'h00, 32'h00FF_0000);
    push_cmd(8'h00, 32'hFF00_0000);
    push_cmd(8'h3C, 32'h1234_5678);
    wait_idle();

    // Phase 2: low/high markers; unmapped writes must leave them alone
    write_reg(cfb_pkg::RegStartByte, 8'h00);
    write_reg(cfb_pkg::RegEndByte, 8'hFF);
    write_reg(RegUnmapped, 8'h12);
    write_reg(RegTopIndex, 8'h34);
    push_cmd(8'h00, 32'h0000_0000);
    push_cmd(8'hFF, 32'hFFFF_FFFF);
    push_cmd(8'hC3, 32'hDEAD_BEEF);
    push_cmd(8'h7F, 32'h7FFF_FFFE);
    push_random(26);
    wait_idle();

    // Phase 3: swapped extremes, long receiver hold-off while commands keep coming
    write_reg(cfb_pkg::RegStartByte, 8'hFF);
    write_reg(cfb_pkg::RegEndByte, 8'h00);
    hold_token++;
    push_random(40);
    wait_idle();

    // Phase 4: random markers
    write_reg(cfb_pkg::RegEndByte, 8'($urandom_range(0, 255)));
    write_reg(cfb_pkg::RegStartByte, 8'($urandom_range(0, 255)));
    push_random(20);
    wait_idle();

    // Phase 5: back to the reset markers
    write_reg(cfb_pkg::RegStartByte, cfb_pkg::StartReset);
    write_reg(cfb_pkg::RegEndByte, cfb_pkg::EndReset);
    push_random(10);
    wait_idle();

    $display("Covered %0d commands and %0d frame bytes across 5 marker settings",
             cmds_taken, bytes_seen);
    $display("with %0d register writes (unmapped ones included), %0d mismatches",
             cfg_writes, err_count);
    if (err_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
